@@ rtl/ndd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, status codes and default sizes for the Newton divided-difference interpolator.
// Depends on nothing; ndd_dp, ndd_ctrl and the top level refer to it by scoped names.
package ndd_pkg;

    localparam int DATA_W          = 32;
    localparam int MAX_POINTS_DEF  = 16;
    localparam int FRAC_BITS_DEF   = 16;

    typedef logic [2:0] status_t;

    localparam status_t ST_OK       = 3'd0;
    localparam status_t ST_DUP_NODE = 3'd1;
    localparam status_t ST_NO_POINTS = 3'd2;
    localparam status_t ST_OVERFLOW = 3'd3;
    localparam status_t ST_SATURATED = 3'd4;

    typedef struct packed {
        logic                       mode;
        logic signed [DATA_W-1:0]   sample_x;
        logic signed [DATA_W-1:0]   sample_y;
        logic                       last_point;
        logic signed [DATA_W-1:0]   query_x;
    } request_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]   value;
        status_t                    status;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ld_we;      // store a sample point
        logic cf_we;      // write back a divided difference
        logic ev_init;    // start an evaluation
        logic mul_en;     // load the product register
        logic mul_sel;    // 0: coef times prod, 1: prod times difference
        logic d_en;       // load the saturated difference
        logic acc_en;     // add the current term
        logic prod_en;    // load the running product
        logic div_start;  // launch a division
        logic res_load;   // capture the result value
        logic res_zero;   // result value is zero
        logic sat_clr;    // clear the sticky saturation flag
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic den_zero;
        logic div_done;
        logic sat;
    } dp_status_t;

endpackage

@@ rtl/ndd_div.sv @@
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing but its parameter; used by ndd_dp.
module ndd_div #(
    parameter int NUM_W = 48
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [31:0]       den,
    output logic [NUM_W-1:0]  quot,
    output logic              done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [31:0]      rem_reg, rem_next;
    logic [31:0]      den_reg, den_next;
    logic [NUM_W-1:0] q_reg, q_next;

    logic [32:0] rem_sh;
    logic        ge;

    always_comb
    begin
        rem_sh    = {rem_reg, q_reg[NUM_W-1]};
        ge        = rem_sh >= {1'b0, den_reg};
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        if (start)
        begin
            cnt_next = CNT_W'(NUM_W);
            run_next = 1'b1;
            rem_next = '0;
            den_next = den;
            q_next   = num;
        end
        else if (run_reg)
        begin
            rem_next = ge ? 32'(rem_sh - {1'b0, den_reg}) : rem_sh[31:0];
            q_next   = {q_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign quot = q_reg;
    assign done = done_reg;

endmodule

@@ rtl/ndd_dp.sv @@
`timescale 1ns / 1ps
// Datapath: node and coefficient memories, divider, shared multiplier and accumulator.
// Depends on ndd_pkg and ndd_div.
module ndd_dp #(
    parameter int MAX_POINTS = ndd_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = ndd_pkg::FRAC_BITS_DEF,
    localparam int AW        = $clog2(MAX_POINTS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ndd_pkg::cmd_t       cmd,
    input  logic [AW-1:0]       wr_addr,
    input  logic [AW-1:0]       rd_a,
    input  logic [AW-1:0]       rd_xb,
    input  logic [AW-1:0]       rd_cb,
    input  logic signed [31:0]  sample_x,
    input  logic signed [31:0]  sample_y,
    input  logic signed [31:0]  query_x,
    output ndd_pkg::dp_status_t sts,
    output logic signed [31:0]  value
);

    localparam int NUM_W = 32 + FRAC_BITS;
    localparam logic signed [31:0] ONE_FX = 32'(64'd1 << FRAC_BITS);
    localparam logic signed [31:0] MAX32  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN32  = 32'sh8000_0000;

    logic signed [31:0] node_mem [MAX_POINTS];
    logic signed [31:0] coef_mem [MAX_POINTS];

    logic signed [31:0] xa_reg, xb_reg, ca_reg, cb_reg;
    logic signed [31:0] x_reg, acc_reg, prod_reg, d_reg, value_reg;
    logic signed [63:0] mul_reg;
    logic               qneg_reg;
    logic               sat_reg;

    logic signed [32:0] den, num, dx, sum;
    logic [31:0]        den_mag, num_mag;
    logic [NUM_W-1:0]   quot;
    logic               div_done;
    logic signed [31:0] quot_sat, d_sat, term, acc_new, prod_new;
    logic signed [63:0] mul_sh;
    logic               q_ovf, d_ovf, m_ovf, s_ovf, sat_now;
    logic signed [31:0] mul_a, mul_b;

    always_ff @(posedge clk)
    begin
        if (cmd.ld_we)
        begin
            node_mem[wr_addr] <= sample_x;
            coef_mem[wr_addr] <= sample_y;
        end
        else if (cmd.cf_we)
        begin
            coef_mem[wr_addr] <= quot_sat;
        end
        xa_reg <= node_mem[rd_a];
        xb_reg <= node_mem[rd_xb];
        ca_reg <= coef_mem[rd_a];
        cb_reg <= coef_mem[rd_cb];
    end

    // Divided difference operands in sign-magnitude form.
    always_comb
    begin
        den     = {xa_reg[31], xa_reg} - {xb_reg[31], xb_reg};
        num     = {ca_reg[31], ca_reg} - {cb_reg[31], cb_reg};
        den_mag = den[32] ? 32'(-den) : den[31:0];
        num_mag = num[32] ? 32'(-num) : num[31:0];
    end

    ndd_div #(.NUM_W(NUM_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   ({num_mag, FRAC_BITS'(0)}),
        .den   (den_mag),
        .quot  (quot),
        .done  (div_done)
    );

    // Quotient saturation, then the evaluation arithmetic.
    always_comb
    begin
        if (qneg_reg)
        begin
            q_ovf    = (|quot[NUM_W-1:32]) | (quot[31] & (|quot[30:0]));
            quot_sat = q_ovf ? MIN32 : 32'(-quot[31:0]);
        end
        else
        begin
            q_ovf    = (|quot[NUM_W-1:32]) | quot[31];
            quot_sat = q_ovf ? MAX32 : quot[31:0];
        end

        dx    = {x_reg[31], x_reg} - {xa_reg[31], xa_reg};
        d_ovf = dx[32] != dx[31];
        d_sat = d_ovf ? (dx[32] ? MIN32 : MAX32) : dx[31:0];

        mul_sh = mul_reg >>> FRAC_BITS;
        m_ovf  = !((&mul_sh[63:31]) || !(|mul_sh[63:31]));
        term   = m_ovf ? (mul_sh[63] ? MIN32 : MAX32) : mul_sh[31:0];

        sum     = {acc_reg[31], acc_reg} + {term[31], term};
        s_ovf   = sum[32] != sum[31];
        acc_new = s_ovf ? (sum[32] ? MIN32 : MAX32) : sum[31:0];

        prod_new = term;

        sat_now = (cmd.cf_we & q_ovf) | (cmd.d_en & d_ovf) |
                  (cmd.acc_en & (m_ovf | s_ovf)) | (cmd.prod_en & m_ovf);

        mul_a = cmd.mul_sel ? prod_reg : ca_reg;
        mul_b = cmd.mul_sel ? d_reg : prod_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            qneg_reg <= num[32] ^ den[32];
        end
        if (cmd.ev_init)
        begin
            x_reg    <= query_x;
            acc_reg  <= '0;
            prod_reg <= ONE_FX;
        end
        else
        begin
            if (cmd.acc_en)
            begin
                acc_reg <= acc_new;
            end
            if (cmd.prod_en)
            begin
                prod_reg <= prod_new;
            end
        end
        if (cmd.d_en)
        begin
            d_reg <= d_sat;
        end
        if (cmd.mul_en)
        begin
            mul_reg <= mul_a * mul_b;
        end
        if (cmd.res_load)
        begin
            value_reg <= cmd.res_zero ? '0 : (cmd.acc_en ? acc_new : acc_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg <= 1'b0;
        end
        else
        begin
            sat_reg <= cmd.sat_clr ? 1'b0 : (sat_reg | sat_now);
        end
    end

    assign sts.den_zero = (den == '0);
    assign sts.div_done = div_done;
    assign sts.sat      = sat_reg | sat_now;
    assign value        = value_reg;

endmodule

@@ rtl/ndd_ctrl.sv @@
`timescale 1ns / 1ps
// Controller: point bookkeeping, coefficient build and evaluation sequencing.
// Depends on ndd_pkg; drives ndd_dp through command and status structs.
module ndd_ctrl #(
    parameter int MAX_POINTS = ndd_pkg::MAX_POINTS_DEF,
    localparam int AW        = $clog2(MAX_POINTS),
    localparam int CW        = $clog2(MAX_POINTS + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                mode,
    input  logic                last_point,
    input  ndd_pkg::dp_status_t sts,
    output logic                busy,
    output logic                done,
    output ndd_pkg::status_t    status,
    output ndd_pkg::cmd_t       cmd,
    output logic [AW-1:0]       wr_addr,
    output logic [AW-1:0]       rd_a,
    output logic [AW-1:0]       rd_xb,
    output logic [AW-1:0]       rd_cb
);

    typedef enum logic [3:0] {
        S_IDLE, S_BINIT, S_BRD, S_BCHK, S_BDIV, S_BWR,
        S_ERD, S_EM1, S_EACC, S_EM2, S_EPROD
    } state_t;

    state_t           state_reg;
    logic [CW-1:0]    cnt_reg, i_reg, j_reg;
    logic             closed_reg, ovf_reg, dup_reg;
    logic             done_reg;
    ndd_pkg::status_t status_reg;

    logic [CW-1:0]    eff_cnt, i_m_j, i_m_1;
    logic             room, accept, no_set;
    ndd_pkg::status_t build_st, eval_st;

    always_comb
    begin
        accept   = start && (state_reg == S_IDLE);
        eff_cnt  = closed_reg ? '0 : cnt_reg;
        room     = eff_cnt < CW'(MAX_POINTS);
        no_set   = !closed_reg || (cnt_reg == '0);
        i_m_j    = i_reg - j_reg;
        i_m_1    = i_reg - CW'(1);
        build_st = ovf_reg ? ndd_pkg::ST_OVERFLOW :
                   (sts.sat ? ndd_pkg::ST_SATURATED : ndd_pkg::ST_OK);
        eval_st  = sts.sat ? ndd_pkg::ST_SATURATED :
                   (ovf_reg ? ndd_pkg::ST_OVERFLOW : ndd_pkg::ST_OK);
        rd_a     = i_reg[AW-1:0];
        rd_xb    = i_m_j[AW-1:0];
        rd_cb    = i_m_1[AW-1:0];
        wr_addr  = (state_reg == S_IDLE) ? eff_cnt[AW-1:0] : i_reg[AW-1:0];

        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!mode)
                    begin
                        cmd.ld_we   = room;
                        cmd.sat_clr = last_point;
                    end
                    else if (no_set || dup_reg)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_zero = 1'b1;
                    end
                    else
                    begin
                        cmd.ev_init = 1'b1;
                        cmd.sat_clr = 1'b1;
                    end
                end
            end
            S_BINIT:
            begin
                cmd.res_load = cnt_reg < CW'(2);
                cmd.res_zero = 1'b1;
            end
            S_BRD:
            begin
            end
            S_BCHK:
            begin
                cmd.div_start = !sts.den_zero;
                cmd.res_load  = sts.den_zero;
                cmd.res_zero  = 1'b1;
            end
            S_BDIV:
            begin
            end
            S_BWR:
            begin
                cmd.cf_we    = 1'b1;
                cmd.res_load = !(i_reg > j_reg) && !((j_reg + CW'(1)) < cnt_reg);
                cmd.res_zero = 1'b1;
            end
            S_ERD:
            begin
            end
            S_EM1:
            begin
                cmd.mul_en = 1'b1;
                // The difference is only formed when another term follows.
                cmd.d_en   = (i_reg + CW'(1)) < cnt_reg;
            end
            S_EACC:
            begin
                cmd.acc_en   = 1'b1;
                cmd.res_load = !((i_reg + CW'(1)) < cnt_reg);
            end
            S_EM2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = 1'b1;
            end
            S_EPROD:
            begin
                cmd.prod_en = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            closed_reg <= 1'b0;
            ovf_reg    <= 1'b0;
            dup_reg    <= 1'b0;
            done_reg   <= 1'b0;
            status_reg <= ndd_pkg::ST_OK;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (!mode)
                        begin
                            // A load into a closed set opens a new one.
                            if (closed_reg)
                            begin
                                dup_reg <= 1'b0;
                            end
                            if (room)
                            begin
                                cnt_reg <= eff_cnt + CW'(1);
                                ovf_reg <= closed_reg ? 1'b0 : ovf_reg;
                            end
                            else
                            begin
                                cnt_reg <= eff_cnt;
                                ovf_reg <= 1'b1;
                            end
                            closed_reg <= last_point;
                            if (last_point)
                            begin
                                state_reg <= S_BINIT;
                            end
                        end
                        else if (no_set)
                        begin
                            done_reg   <= 1'b1;
                            status_reg <= ndd_pkg::ST_NO_POINTS;
                        end
                        else if (dup_reg)
                        begin
                            done_reg   <= 1'b1;
                            status_reg <= ndd_pkg::ST_DUP_NODE;
                        end
                        else
                        begin
                            i_reg     <= '0;
                            state_reg <= S_ERD;
                        end
                    end
                end
                S_BINIT:
                begin
                    if (cnt_reg < CW'(2))
                    begin
                        done_reg   <= 1'b1;
                        status_reg <= build_st;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        j_reg     <= CW'(1);
                        i_reg     <= cnt_reg - CW'(1);
                        state_reg <= S_BRD;
                    end
                end
                S_BRD:
                begin
                    state_reg <= S_BCHK;
                end
                S_BCHK:
                begin
                    if (sts.den_zero)
                    begin
                        dup_reg    <= 1'b1;
                        done_reg   <= 1'b1;
                        status_reg <= ndd_pkg::ST_DUP_NODE;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_BDIV;
                    end
                end
                S_BDIV:
                begin
                    if (sts.div_done)
                    begin
                        state_reg <= S_BWR;
                    end
                end
                S_BWR:
                begin
                    if (i_reg > j_reg)
                    begin
                        i_reg     <= i_m_1;
                        state_reg <= S_BRD;
                    end
                    else if ((j_reg + CW'(1)) < cnt_reg)
                    begin
                        j_reg     <= j_reg + CW'(1);
                        i_reg     <= cnt_reg - CW'(1);
                        state_reg <= S_BRD;
                    end
                    else
                    begin
                        done_reg   <= 1'b1;
                        status_reg <= build_st;
                        state_reg  <= S_IDLE;
                    end
                end
                S_ERD:
                begin
                    state_reg <= S_EM1;
                end
                S_EM1:
                begin
                    state_reg <= S_EACC;
                end
                S_EACC:
                begin
                    if ((i_reg + CW'(1)) < cnt_reg)
                    begin
                        state_reg <= S_EM2;
                    end
                    else
                    begin
                        done_reg   <= 1'b1;
                        status_reg <= eval_st;
                        state_reg  <= S_IDLE;
                    end
                end
                S_EM2:
                begin
                    state_reg <= S_EPROD;
                end
                S_EPROD:
                begin
                    i_reg     <= i_reg + CW'(1);
                    state_reg <= S_ERD;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;

endmodule

@@ rtl/newton_divided_difference_interp.sv @@
`timescale 1ns / 1ps
// Top level of the Newton divided-difference interpolator.
// Depends on ndd_pkg, ndd_ctrl and ndd_dp (which holds ndd_div).
//
// Usage. A request transfer happens at a rising edge where start is high and
// busy is low. With mode 0 the request loads one sample point; a point with
// last_point set closes the set and builds the Newton coefficients in place.
// With mode 1 the request evaluates the polynomial at query_x. A load that
// does not close the set gives no result; every other request gives exactly
// one result transfer: done is high for one cycle with value and status.
// The receiver cannot stall; a result must be taken in the cycle it is shown.
//
// Operation. A closing load runs one division per coefficient pair,
// n(n-1)/2 of them for n points, in the serial divider, which sets the build
// time. An evaluation uses one shared 32x32 multiplier twice per node, once
// for the last node. Query errors answer in the cycle after the request.
// Reset clears the point count and all flags; the stores hold no valid data
// until loaded, and only entries of the current set are ever read.
module newton_divided_difference_interp #(
    parameter int MAX_POINTS = ndd_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = ndd_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ndd_pkg::request_t request,
    output logic              busy,
    output logic              done,
    output ndd_pkg::result_t  result
);

    localparam int AW = $clog2(MAX_POINTS);

    ndd_pkg::cmd_t       cmd;
    ndd_pkg::dp_status_t sts;
    ndd_pkg::status_t    status;
    logic [AW-1:0]       wr_addr, rd_a, rd_xb, rd_cb;
    logic signed [31:0]  value;

    // The controller owns the point count and the set flags.
    ndd_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .mode       (request.mode),
        .last_point (request.last_point),
        .sts        (sts),
        .busy       (busy),
        .done       (done),
        .status     (status),
        .cmd        (cmd),
        .wr_addr    (wr_addr),
        .rd_a       (rd_a),
        .rd_xb      (rd_xb),
        .rd_cb      (rd_cb)
    );

    // The datapath owns the memories and all arithmetic.
    ndd_dp #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .wr_addr  (wr_addr),
        .rd_a     (rd_a),
        .rd_xb    (rd_xb),
        .rd_cb    (rd_cb),
        .sample_x (request.sample_x),
        .sample_y (request.sample_y),
        .query_x  (request.query_x),
        .sts      (sts),
        .value    (value)
    );

    assign result.value  = value;
    assign result.status = status;

    // A result is only presented once the sequence has returned to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // Sample points are only written from an accepted load request.
    a_load_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ld_we |-> (start && !busy && !request.mode))
        else $error("point stored without a load transfer");

    // Error results always carry a zero value.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ndd_pkg::ST_NO_POINTS ||
                  result.status == ndd_pkg::ST_DUP_NODE)) |-> (result.value == '0))
        else $error("error result with nonzero value");

    // A division is only launched while a build is in progress.
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> busy)
        else $error("division started while idle");

endmodule
